>>> design/gpm_pkg.sv
// Package for genotype pair match histogram: types, codes and field widths.
package gpm_pkg;

    localparam int ALLELE_W   = 10;
    localparam int FIELD_W    = 6;
    localparam int CELL_OUT_W = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LOCI      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 4'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] NUM_LOCI_RST      = 6'd16;
    localparam logic [CFG_DATA_W-1:0] HIT_THRESHOLD_RST = 6'd32;

    // Result kinds
    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_CELL = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_REF   = 2'd0,
        OP_COMPARE    = 2'd1,
        OP_READ_CELL  = 2'd2,
        OP_CLEAR_HIST = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COMPARE,
        ST_HIST_RD,
        ST_HIST_WR,
        ST_CELL_RD
    } state_t;

    typedef struct packed {
        op_t                 op;
        logic [ALLELE_W-1:0] allele_first;
        logic [ALLELE_W-1:0] allele_second;
        logic [FIELD_W-1:0]  full_index;
        logic [FIELD_W-1:0]  partial_index;
    } cmd_t;

    typedef struct packed {
        logic                  kind;
        logic [FIELD_W-1:0]    full_matches;
        logic [FIELD_W-1:0]    partial_matches;
        logic                  hit;
        logic [CELL_OUT_W-1:0] cell_count;
    } res_t;

endpackage

>>> design/gpm_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module gpm_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/genotype_pair_match_histogram.sv
// Top level of the genotype pair match histogram block.
//
// Usage: requests arrive on cmd (cmd_valid/cmd_ready), one op per request.
//   LOAD_REF writes one reference locus, COMPARE checks one candidate locus
//   against the reference locus at the shared position, READ_CELL reads one
//   histogram cell, CLEAR_HIST zeroes the histogram. Results leave on res
//   (res_valid/res_ready): a pair result after the last candidate locus, a
//   cell value after each READ_CELL. cfg (cfg_valid/cfg_ready) writes
//   num_loci and hit_threshold; cfg_ready is always high.
// Sequence: LOAD_REF stays in ST_IDLE. COMPARE reads the reference RAM on
//   acceptance, then compares in ST_COMPARE. The last locus of a pair then
//   passes ST_HIST_RD and ST_HIST_WR, where its result is registered: the
//   histogram cell read and the saturating write-back go through the single
//   histogram RAM. READ_CELL reads on acceptance and registers in ST_CELL_RD.
// Reset and CLEAR_HIST: the histogram RAM, (MAX_LOCI+1)^2 cells (1089 at
//   defaults), is swept one cell per cycle with cmd_ready low.
// Stall: the result register frees the engine while res is held; a new
//   result waits in its final state until the result register is free.
module genotype_pair_match_histogram #(
    parameter int MAX_LOCI   = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  gpm_pkg::cmd_t                    cmd,
    output logic                             res_valid,
    input  logic                             res_ready,
    output gpm_pkg::res_t                    res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int POS_W      = (MAX_LOCI > 1) ? $clog2(MAX_LOCI) : 1;
    localparam int CNT_W      = $clog2(MAX_LOCI + 1);
    localparam int CMP_W      = (CNT_W > gpm_pkg::CFG_DATA_W) ? CNT_W : gpm_pkg::CFG_DATA_W;
    // tallies carry a sticky top bit: loads that wrap the position can keep
    // a pair open past any locus count, and such a pair must stay out of range
    localparam int RUN_W      = CMP_W + 1;
    localparam logic [RUN_W-1:0] RUN_TOP = {1'b1, {(RUN_W-1){1'b0}}};
    localparam int HIST_DIM   = MAX_LOCI + 1;
    localparam int HIST_DEPTH = HIST_DIM * HIST_DIM;
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam int REF_W      = 2 * gpm_pkg::ALLELE_W;

    gpm_pkg::state_t state_reg, state_next;

    logic [POS_W-1:0]               pos_reg;
    logic [RUN_W-1:0]               full_reg;
    logic [RUN_W-1:0]               part_reg;
    logic                           last_reg;
    logic [gpm_pkg::ALLELE_W-1:0]   cand_first_reg;
    logic [gpm_pkg::ALLELE_W-1:0]   cand_second_reg;
    logic                           cell_ok_reg;
    logic [HA_W-1:0]                clr_addr_reg;
    logic [HA_W-1:0]                hist_addr_reg;
    logic                           res_valid_reg;
    gpm_pkg::res_t                  res_reg;
    logic [gpm_pkg::CFG_DATA_W-1:0] num_loci_reg;
    logic [gpm_pkg::CFG_DATA_W-1:0] hit_thr_reg;

    // control
    logic cmd_fire;
    logic slot_free;
    logic ref_wr_en, ref_rd_en;
    logic hist_wr_en, hist_rd_en;
    logic [HA_W-1:0]       hist_wr_addr, hist_rd_addr;
    logic [COUNT_BITS-1:0] hist_wr_data;
    logic pair_done, cell_done;

    // datapath
    logic [CNT_W-1:0]      loci_n;
    logic                  pos_last;
    logic [REF_W-1:0]      ref_rd_data;
    logic [COUNT_BITS-1:0] hist_rd_data;
    logic [HA_W-1:0]       pair_addr;
    logic                  pair_in_range;
    logic [HA_W-1:0]       cell_addr;
    logic                  cell_in_range;
    logic                  m_ac, m_ad, m_bc, m_bd;
    logic                  locus_full, locus_part;

    assign cmd_fire  = cmd_valid && cmd_ready;
    assign slot_free = !res_valid_reg || res_ready;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // loci in use, clamped to 1..MAX_LOCI
    always_comb
    begin
        if (num_loci_reg == '0)
        begin
            loci_n = CNT_W'(1);
        end
        else if (32'(num_loci_reg) > 32'(MAX_LOCI))
        begin
            loci_n = CNT_W'(MAX_LOCI);
        end
        else
        begin
            loci_n = CNT_W'(num_loci_reg);
        end
    end

    assign pos_last = (32'(pos_reg) + 32'd1) >= 32'(loci_n);

    // locus compare against the reference read
    always_comb
    begin
        m_ac       = ref_rd_data[REF_W-1 -: gpm_pkg::ALLELE_W] == cand_first_reg;
        m_ad       = ref_rd_data[REF_W-1 -: gpm_pkg::ALLELE_W] == cand_second_reg;
        m_bc       = ref_rd_data[gpm_pkg::ALLELE_W-1:0] == cand_first_reg;
        m_bd       = ref_rd_data[gpm_pkg::ALLELE_W-1:0] == cand_second_reg;
        locus_part = (m_ac != m_bd) || (m_ad != m_bc);
        locus_full = (m_ac && m_bd) || (m_ad && m_bc);
    end

    // histogram addressing: row-major, HIST_DIM columns
    assign pair_addr = HA_W'(32'(full_reg) * HIST_DIM + 32'(part_reg));
    // a pair with a tally past MAX_LOCI has no cell and bumps nothing
    assign pair_in_range = (32'(full_reg) <= 32'(MAX_LOCI))
                        && (32'(part_reg) <= 32'(MAX_LOCI));
    assign cell_in_range = (32'(cmd.full_index) <= 32'(MAX_LOCI))
                        && (32'(cmd.partial_index) <= 32'(MAX_LOCI));
    assign cell_addr = cell_in_range
                     ? HA_W'(32'(cmd.full_index) * HIST_DIM + 32'(cmd.partial_index))
                     : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gpm_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == HA_W'(HIST_DEPTH - 1))
                begin
                    state_next = gpm_pkg::ST_IDLE;
                end
            end
            gpm_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.op)
                        gpm_pkg::OP_LOAD_REF:   state_next = gpm_pkg::ST_IDLE;
                        gpm_pkg::OP_COMPARE:    state_next = gpm_pkg::ST_COMPARE;
                        gpm_pkg::OP_READ_CELL:  state_next = gpm_pkg::ST_CELL_RD;
                        gpm_pkg::OP_CLEAR_HIST: state_next = gpm_pkg::ST_CLEAR;
                        default:                state_next = gpm_pkg::ST_IDLE;
                    endcase
                end
            end
            gpm_pkg::ST_COMPARE:
            begin
                state_next = last_reg ? gpm_pkg::ST_HIST_RD : gpm_pkg::ST_IDLE;
            end
            gpm_pkg::ST_HIST_RD:
            begin
                state_next = gpm_pkg::ST_HIST_WR;
            end
            gpm_pkg::ST_HIST_WR:
            begin
                if (slot_free)
                begin
                    state_next = gpm_pkg::ST_IDLE;
                end
            end
            gpm_pkg::ST_CELL_RD:
            begin
                if (slot_free)
                begin
                    state_next = gpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gpm_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_ready    = 1'b0;
        ref_wr_en    = 1'b0;
        ref_rd_en    = 1'b0;
        hist_wr_en   = 1'b0;
        hist_rd_en   = 1'b0;
        hist_wr_addr = clr_addr_reg;
        hist_rd_addr = pair_addr;
        hist_wr_data = '0;
        pair_done    = 1'b0;
        cell_done    = 1'b0;
        unique case (state_reg)
            gpm_pkg::ST_CLEAR:
            begin
                hist_wr_en = 1'b1;
            end
            gpm_pkg::ST_IDLE:
            begin
                cmd_ready    = 1'b1;
                ref_wr_en    = cmd_valid && (cmd.op == gpm_pkg::OP_LOAD_REF);
                ref_rd_en    = cmd_valid && (cmd.op == gpm_pkg::OP_COMPARE);
                hist_rd_en   = cmd_valid && (cmd.op == gpm_pkg::OP_READ_CELL);
                hist_rd_addr = cell_addr;
            end
            gpm_pkg::ST_COMPARE:
            begin
            end
            gpm_pkg::ST_HIST_RD:
            begin
                hist_rd_en = 1'b1;
            end
            gpm_pkg::ST_HIST_WR:
            begin
                pair_done    = slot_free;
                hist_wr_en   = slot_free && pair_in_range;
                hist_wr_addr = hist_addr_reg;
                // saturate at all ones
                hist_wr_data = (hist_rd_data == '1) ? hist_rd_data
                                                    : hist_rd_data + COUNT_BITS'(1);
            end
            gpm_pkg::ST_CELL_RD:
            begin
                cell_done = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    gpm_ram #(
        .WIDTH (REF_W),
        .DEPTH (MAX_LOCI)
    ) u_ref_ram (
        .clk     (clk),
        .wr_en   (ref_wr_en),
        .wr_addr (pos_reg),
        .wr_data ({cmd.allele_first, cmd.allele_second}),
        .rd_en   (ref_rd_en),
        .rd_addr (pos_reg),
        .rd_data (ref_rd_data)
    );

    gpm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_wr_en),
        .wr_addr (hist_wr_addr),
        .wr_data (hist_wr_data),
        .rd_en   (hist_rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_loci_reg <= gpm_pkg::NUM_LOCI_RST;
            hit_thr_reg  <= gpm_pkg::HIT_THRESHOLD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gpm_pkg::REG_NUM_LOCI:      num_loci_reg <= cfg_data;
                gpm_pkg::REG_HIT_THRESHOLD: hit_thr_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gpm_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            full_reg      <= '0;
            part_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == gpm_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + HA_W'(1);
            end
            else
            begin
                clr_addr_reg <= '0;
            end

            // shared locus position for load and compare
            if (cmd_fire && ((cmd.op == gpm_pkg::OP_LOAD_REF)
                          || (cmd.op == gpm_pkg::OP_COMPARE)))
            begin
                pos_reg <= pos_last ? '0 : pos_reg + POS_W'(1);
            end

            if (state_reg == gpm_pkg::ST_COMPARE)
            begin
                full_reg <= (full_reg + RUN_W'(locus_full)) | (full_reg & RUN_TOP);
                part_reg <= (part_reg + RUN_W'(locus_part)) | (part_reg & RUN_TOP);
            end
            else if (pair_done)
            begin
                full_reg <= '0;
                part_reg <= '0;
            end

            if (pair_done || cell_done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cand_first_reg  <= cmd.allele_first;
            cand_second_reg <= cmd.allele_second;
            last_reg        <= pos_last;
            cell_ok_reg     <= cell_in_range;
        end
        if (state_reg == gpm_pkg::ST_HIST_RD)
        begin
            hist_addr_reg <= pair_addr;
        end
        if (pair_done)
        begin
            res_reg.kind            <= gpm_pkg::KIND_PAIR;
            res_reg.full_matches    <= gpm_pkg::FIELD_W'(full_reg);
            res_reg.partial_matches <= gpm_pkg::FIELD_W'(part_reg);
            res_reg.hit             <= full_reg >= RUN_W'(hit_thr_reg);
            res_reg.cell_count      <= '0;
        end
        else if (cell_done)
        begin
            res_reg.kind            <= gpm_pkg::KIND_CELL;
            res_reg.full_matches    <= '0;
            res_reg.partial_matches <= '0;
            res_reg.hit             <= 1'b0;
            res_reg.cell_count      <= cell_ok_reg
                                     ? gpm_pkg::CELL_OUT_W'(hist_rd_data) : '0;
        end
    end

endmodule

>>> design/gpm_checker.sv
// Port-level checker for genotype pair match histogram, bound to the top level.
module gpm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input gpm_pkg::cmd_t                  cmd,
    input logic                           res_valid,
    input logic                           res_ready,
    input gpm_pkg::res_t                  res
);

    // a held result keeps its payload until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.kind == gpm_pkg::KIND_CELL)
        |-> (res.full_matches == '0) && (res.partial_matches == '0) && !res.hit)
        else $error("cell read carries pair fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.kind == gpm_pkg::KIND_PAIR) |-> (res.cell_count == '0))
        else $error("pair result carries a cell count");

    // load and clear requests never produce a result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && !res_valid
        && ((cmd.op == gpm_pkg::OP_LOAD_REF) || (cmd.op == gpm_pkg::OP_CLEAR_HIST))
        |=> !res_valid)
        else $error("result after load or clear request");

    // a cell read keeps the engine busy for its read cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.op == gpm_pkg::OP_READ_CELL) |=> !cmd_ready)
        else $error("request accepted during cell read");

endmodule

bind genotype_pair_match_histogram gpm_checker u_gpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

>>> tb/sv/genotype_pair_match_histogram_test.sv
// Self-checking testbench for the genotype pair match histogram block.
module genotype_pair_match_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOCI_CAP    = 32;
    localparam int CYCLE_LIMIT = 500000;

    // Interface signals; those the bench drives are known from time zero
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cmd_valid = 1'b0;
    logic                           cmd_ready;
    gpm_pkg::cmd_t                  cmd       = '0;
    logic                           res_valid;
    logic                           res_ready = 1'b0;
    gpm_pkg::res_t                  res;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [gpm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gpm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Scoreboard mirror of the block: stored reference profile, shared
    // locus position, running tallies of the open pair, and the histogram.
    logic [gpm_pkg::ALLELE_W-1:0]   stored_first  [LOCI_CAP];
    logic [gpm_pkg::ALLELE_W-1:0]   stored_second [LOCI_CAP];
    bit                             stored_loaded [LOCI_CAP] = '{default: 1'b0};
    int                             locus_pos     = 0;
    int                             run_full      = 0;
    int                             run_partial   = 0;
    logic [31:0]                    hist_bins [0:LOCI_CAP][0:LOCI_CAP] = '{default: '0};
    logic [gpm_pkg::CFG_DATA_W-1:0] cfg_loci      = gpm_pkg::NUM_LOCI_RST;
    logic [gpm_pkg::CFG_DATA_W-1:0] cfg_threshold = gpm_pkg::HIT_THRESHOLD_RST;

    gpm_pkg::res_t                  scores_due [$];   // results the block still owes us
    bit                             pair_closed   = 1'b0;
    bit                             clear_pending = 1'b0;
    bit                             steady        = 1'b0;

    int                             errors          = 0;
    int                             requests_sent   = 0;
    int                             pairs_checked   = 0;
    int                             reads_checked   = 0;
    int                             config_settings = 0;
    int                             cycles          = 0;

    genotype_pair_match_histogram #(
        .MAX_LOCI   (LOCI_CAP),
        .COUNT_BITS (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, scores_due.size());
            $display("genotype_pair_match_histogram_test: done, errors");
            $finish;
        end
    end

    // Register value 0 behaves as one locus, anything past the cap as the cap
    function automatic int loci_in_use();
        if (cfg_loci == 0)
            return 1;
        if (cfg_loci > LOCI_CAP)
            return LOCI_CAP;
        return int'(cfg_loci);
    endfunction

    // Advance the mirror by one accepted request and queue what it owes.
    function automatic void score_request(input gpm_pkg::cmd_t c);
        gpm_pkg::res_t                r;
        int                           n;
        int                           p;
        int                           i;
        int                           j;
        logic [gpm_pkg::ALLELE_W-1:0] r1;
        logic [gpm_pkg::ALLELE_W-1:0] r2;
        logic                         ac;
        logic                         ad;
        logic                         bc;
        logic                         bd;
        n = loci_in_use();
        p = locus_pos;
        r = '0;
        pair_closed = 1'b0;
        case (c.op)
            gpm_pkg::OP_LOAD_REF:
            begin
                // Loads share the position with compares but leave tallies alone
                stored_first[p]  = c.allele_first;
                stored_second[p] = c.allele_second;
                stored_loaded[p] = 1'b1;
                locus_pos = (p + 1 >= n) ? 0 : p + 1;
            end
            gpm_pkg::OP_COMPARE:
            begin
                r1 = stored_first[p];
                r2 = stored_second[p];
                ac = (r1 == c.allele_first);
                ad = (r1 == c.allele_second);
                bc = (r2 == c.allele_first);
                bd = (r2 == c.allele_second);
                // Straight or crossed pairing half met -> partial; fully met -> full
                if ((ac != bd) || (ad != bc))
                    run_partial++;
                if ((ac && bd) || (ad && bc))
                    run_full++;
                // A position at or past a lowered count also closes the pair
                if (p + 1 >= n)
                begin
                    locus_pos = 0;
                    if (run_full <= LOCI_CAP && run_partial <= LOCI_CAP)
                    begin
                        if (hist_bins[run_full][run_partial] != 32'hFFFF_FFFF)
                            hist_bins[run_full][run_partial]++;
                    end
                    r.kind            = gpm_pkg::KIND_PAIR;
                    r.full_matches    = 6'(run_full);
                    r.partial_matches = 6'(run_partial);
                    r.hit             = (run_full >= int'(cfg_threshold));
                    scores_due = {scores_due, r};
                    pair_closed = 1'b1;
                    run_full    = 0;
                    run_partial = 0;
                end
                else
                begin
                    locus_pos = p + 1;
                end
            end
            gpm_pkg::OP_READ_CELL:
            begin
                // Row or column past the cap reads as zero
                r.kind = gpm_pkg::KIND_CELL;
                if (c.full_index <= LOCI_CAP && c.partial_index <= LOCI_CAP)
                    r.cell_count = hist_bins[c.full_index][c.partial_index];
                scores_due = {scores_due, r};
            end
            default:
            begin
                for (i = 0; i <= LOCI_CAP; i++)
                    for (j = 0; j <= LOCI_CAP; j++)
                        hist_bins[i][j] = '0;
                clear_pending = 1'b1;
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("t=%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_result(input gpm_pkg::res_t got);
        gpm_pkg::res_t want;
        if (scores_due.size() == 0)
        begin
            errors++;
            $display("t=%0t unexpected result: kind %0d full %0d partial %0d hit %0d count %0d",
                     $time, got.kind, got.full_matches, got.partial_matches, got.hit,
                     got.cell_count);
            return;
        end
        want = scores_due.pop_front();
        if (want.kind == gpm_pkg::KIND_PAIR)
            pairs_checked++;
        else
            reads_checked++;
        compare_field("kind", 32'(want.kind), 32'(got.kind));
        compare_field("full_matches", 32'(want.full_matches), 32'(got.full_matches));
        compare_field("partial_matches", 32'(want.partial_matches),
                      32'(got.partial_matches));
        compare_field("hit", 32'(want.hit), 32'(got.hit));
        compare_field("cell_count", want.cell_count, got.cell_count);
    endfunction

    // Result side: check on every completed handshake, then pick the next ready.
    // Ready is low about 18 percent of the time except during steady stretches.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            check_result(res);
        res_ready <= steady || ($urandom_range(99) >= 18);
    end

    // Allele codes lean on the extremes and a small pool so that matches happen
    function automatic logic [gpm_pkg::ALLELE_W-1:0] random_allele();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll < 5)
            return gpm_pkg::ALLELE_W'($urandom_range(7));
        return gpm_pkg::ALLELE_W'($urandom_range(1023));
    endfunction

    // Any allele code at all
    function automatic logic [gpm_pkg::ALLELE_W-1:0] any_allele();
        return gpm_pkg::ALLELE_W'($urandom_range(1023));
    endfunction

    // Any 6-bit index, in range or not
    function automatic logic [gpm_pkg::FIELD_W-1:0] any_index();
        return gpm_pkg::FIELD_W'($urandom_range(63));
    endfunction

    // Mostly in-range histogram coordinates, sometimes past the cap
    function automatic logic [gpm_pkg::FIELD_W-1:0] pick_index();
        if ($urandom_range(3) == 0)
            return gpm_pkg::FIELD_W'($urandom_range(63));
        return gpm_pkg::FIELD_W'($urandom_range(LOCI_CAP));
    endfunction

    // Candidate locus built from the stored reference at the current position
    function automatic void pick_candidate(output logic [gpm_pkg::ALLELE_W-1:0] a1,
                                           output logic [gpm_pkg::ALLELE_W-1:0] a2);
        logic [gpm_pkg::ALLELE_W-1:0] s1;
        logic [gpm_pkg::ALLELE_W-1:0] s2;
        s1 = stored_first[locus_pos];
        s2 = stored_second[locus_pos];
        case ($urandom_range(5))
            0:
            begin
                a1 = s1;
                a2 = s2;
            end
            1:
            begin
                a1 = s2;
                a2 = s1;
            end
            2:
            begin
                a1 = s1;
                a2 = random_allele();
            end
            3:
            begin
                a1 = random_allele();
                a2 = s2;
            end
            4:
            begin
                a1 = s2;
                a2 = s2;
            end
            default:
            begin
                a1 = random_allele();
                a2 = random_allele();
            end
        endcase
    endfunction

    // Send one request. Valid only drops for a random gap; otherwise the next
    // request follows straight on from the accepting edge.
    task automatic send_request(input gpm_pkg::op_t op,
                                input logic [gpm_pkg::ALLELE_W-1:0] a1,
                                input logic [gpm_pkg::ALLELE_W-1:0] a2,
                                input logic [gpm_pkg::FIELD_W-1:0] fi,
                                input logic [gpm_pkg::FIELD_W-1:0] pi);
        gpm_pkg::cmd_t c;
        c.op            = op;
        c.allele_first  = a1;
        c.allele_second = a2;
        c.full_index    = fi;
        c.partial_index = pi;
        if (!steady && $urandom_range(99) < 18)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        score_request(c);
        requests_sent++;
    endtask

    // Quiet the request side until every result is back; a clear still
    // sweeping the histogram gets its full sweep time on top.
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (scores_due.size() != 0)
            @(posedge clk);
        repeat (clear_pending ? 1200 : 8) @(posedge clk);
        clear_pending = 1'b0;
    endtask

    task automatic write_register(input logic [gpm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [gpm_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == gpm_pkg::REG_NUM_LOCI)
            cfg_loci = val;
        else
            cfg_threshold = val;
    endtask

    task automatic set_config(input logic [gpm_pkg::CFG_DATA_W-1:0] loci,
                              input logic [gpm_pkg::CFG_DATA_W-1:0] thr);
        wait_idle();
        write_register(gpm_pkg::REG_NUM_LOCI, loci);
        write_register(gpm_pkg::REG_HIT_THRESHOLD, thr);
        cfg_valid <= 1'b0;
        config_settings++;
    endtask

    // Stream one candidate until its pair closes; unwritten reference
    // positions get loaded first so no read of an empty entry happens.
    task automatic finish_candidate();
        logic [gpm_pkg::ALLELE_W-1:0] a1;
        logic [gpm_pkg::ALLELE_W-1:0] a2;
        pair_closed = 1'b0;
        while (!pair_closed)
        begin
            if (stored_loaded[locus_pos])
            begin
                pick_candidate(a1, a2);
                send_request(gpm_pkg::OP_COMPARE, a1, a2, any_index(), any_index());
            end
            else
            begin
                send_request(gpm_pkg::OP_LOAD_REF, random_allele(), random_allele(),
                             any_index(), any_index());
            end
        end
    endtask

    // Fully random request; a load is held back while the tallies are high so
    // the open pair never overruns its 6-bit result fields.
    task automatic send_noise();
        gpm_pkg::op_t op;
        op = gpm_pkg::op_t'($urandom_range(3));
        if (op == gpm_pkg::OP_LOAD_REF && (run_full >= 20 || run_partial >= 20))
            op = gpm_pkg::OP_READ_CELL;
        if (op == gpm_pkg::OP_COMPARE && !stored_loaded[locus_pos])
            op = gpm_pkg::OP_READ_CELL;
        send_request(op, any_allele(), any_allele(), any_index(), any_index());
    endtask

    // Directed: extremes of the allele codes, homozygous loci, straight and
    // crossed full matches, partial matches, a load in the middle of a
    // candidate, reads past the cap and a clear.
    task automatic test_directed_cases();
        set_config(6'd4, 6'd2);
        send_request(gpm_pkg::OP_LOAD_REF, 10'd0, 10'd0, 6'd63, 6'd0);
        send_request(gpm_pkg::OP_LOAD_REF, 10'd1023, 10'd1023, 6'd0, 6'd63);
        send_request(gpm_pkg::OP_LOAD_REF, 10'd5, 10'd9, 6'd21, 6'd42);
        send_request(gpm_pkg::OP_LOAD_REF, 10'd300, 10'd700, 6'd42, 6'd21);
        // full, full, crossed full, partial -> 3 full, 1 partial, hit
        send_request(gpm_pkg::OP_COMPARE, 10'd0, 10'd0, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_COMPARE, 10'd1023, 10'd1023, 6'd63, 6'd63);
        send_request(gpm_pkg::OP_COMPARE, 10'd9, 10'd5, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_COMPARE, 10'd300, 10'd1, 6'd0, 6'd0);
        // partial, none, partial against a heterozygous locus, crossed full
        send_request(gpm_pkg::OP_COMPARE, 10'd0, 10'd1023, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_COMPARE, 10'd7, 10'd8, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_COMPARE, 10'd9, 10'd9, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_COMPARE, 10'd700, 10'd300, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_READ_CELL, 10'd1023, 10'd0, 6'd3, 6'd1);
        send_request(gpm_pkg::OP_READ_CELL, 10'd0, 10'd1023, 6'd1, 6'd2);
        send_request(gpm_pkg::OP_READ_CELL, 10'd0, 10'd0, 6'd32, 6'd32);
        send_request(gpm_pkg::OP_READ_CELL, 10'd0, 10'd0, 6'd33, 6'd0);
        send_request(gpm_pkg::OP_READ_CELL, 10'd0, 10'd0, 6'd0, 6'd63);
        send_request(gpm_pkg::OP_READ_CELL, 10'd0, 10'd0, 6'd63, 6'd63);
        // load lands on the candidate's second locus and shifts the rest
        send_request(gpm_pkg::OP_COMPARE, 10'd0, 10'd0, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_LOAD_REF, 10'd5, 10'd5, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_COMPARE, 10'd9, 10'd5, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_COMPARE, 10'd700, 10'd300, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_CLEAR_HIST, 10'd0, 10'd0, 6'd0, 6'd0);
        send_request(gpm_pkg::OP_READ_CELL, 10'd0, 10'd0, 6'd3, 6'd1);
    endtask

    // One random phase under a fixed setting: mostly reference loads and
    // whole candidates with random content, plus reads, clears and noise.
    task automatic run_phase(input logic [gpm_pkg::CFG_DATA_W-1:0] loci,
                             input logic [gpm_pkg::CFG_DATA_W-1:0] thr, input int budget,
                             input bit calm);
        int                           stop_at;
        int                           roll;
        int                           n;
        logic [gpm_pkg::ALLELE_W-1:0] a1;
        logic [gpm_pkg::ALLELE_W-1:0] a2;
        set_config(loci, thr);
        steady  = calm;
        stop_at = requests_sent + budget;
        n       = loci_in_use();
        while (requests_sent < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 12 && run_full < 20 && run_partial < 20)
            begin
                repeat (n)
                begin
                    a1 = random_allele();
                    a2 = ($urandom_range(4) == 0) ? a1 : random_allele();
                    send_request(gpm_pkg::OP_LOAD_REF, a1, a2, any_index(), any_index());
                end
            end
            else if (roll < 78)
            begin
                finish_candidate();
            end
            else if (roll < 91)
            begin
                send_request(gpm_pkg::OP_READ_CELL, any_allele(), any_allele(),
                             pick_index(), pick_index());
            end
            else if (roll < 93)
            begin
                send_request(gpm_pkg::OP_CLEAR_HIST, any_allele(), any_allele(),
                             any_index(), any_index());
            end
            else if (roll < 94)
            begin
                // Hold off until the block has answered everything
                cmd_valid <= 1'b0;
                while (scores_due.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            else
            begin
                send_noise();
            end
        end
        // Leave a candidate part way so the next setting may land mid-pair
        repeat ($urandom_range(n - 1))
        begin
            if (stored_loaded[locus_pos])
            begin
                pick_candidate(a1, a2);
                send_request(gpm_pkg::OP_COMPARE, a1, a2, any_index(), any_index());
            end
        end
        steady = 1'b0;
    endtask

    // Settings walk through the extremes: one locus, zero and oversized
    // counts, a threshold of zero and thresholds past the locus count.
    task automatic test_random_profiles();
        run_phase(6'd32, 6'd32, 300, 1'b0);
        run_phase(6'd1, 6'd0, 200, 1'b0);
        run_phase(6'd0, 6'd63, 150, 1'b0);
        run_phase(6'd63, 6'd20, 300, 1'b1);
        run_phase(6'd5, 6'd3, 300, 1'b0);
        run_phase(6'd12, 6'd12, 250, 1'b0);
        run_phase(6'($urandom_range(2, 31)), 6'($urandom_range(0, 33)), 250, 1'b0);
        run_phase(6'd3, 6'd1, 200, 1'b0);
    endtask

    initial
    begin
        // Reset is held low first; the block then sweeps its histogram
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_profiles();

        // Drain the last results, then allow for the longest pipeline
        cmd_valid <= 1'b0;
        while (scores_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d requests under %0d register settings", requests_sent,
                 config_settings);
        $display("checked %0d pair results and %0d histogram reads", pairs_checked,
                 reads_checked);
        if (errors == 0)
            $display("genotype_pair_match_histogram_test: done, clean");
        else
            $display("genotype_pair_match_histogram_test: done, errors");
        $finish;
    end

endmodule

>>> genotype_pair_match_histogram.f
design/gpm_pkg.sv
design/gpm_ram.sv
design/genotype_pair_match_histogram.sv
design/gpm_checker.sv
tb/sv/genotype_pair_match_histogram_test.sv
